// ===== sv/serial_mouse_packet_decoder_defines.svh =====
// Assertion macros for the serial mouse packet decoder checker.
// No dependencies; included by the checker file only.
`ifndef SERIAL_MOUSE_PACKET_DECODER_DEFINES_SVH
`define SERIAL_MOUSE_PACKET_DECODER_DEFINES_SVH

// Property checked only while out of reset.
`define SMPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define SMPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/smpd_pkg.sv =====
// Shared types and constants for the serial mouse packet decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package smpd_pkg;

    // header marker bit of the byte stream
    localparam int unsigned HdrBit = 6;

    // frame phases
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_B2   = 2'd1;
    localparam logic [1:0] PH_B3   = 2'd2;
    localparam logic [1:0] PH_HELD = 2'd3;

    // input kinds carried in tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    // event codes
    localparam logic [3:0] EV_LEFT_UP  = 4'd0;
    localparam logic [3:0] EV_LEFT_DN  = 4'd1;
    localparam logic [3:0] EV_MID_UP   = 4'd2;
    localparam logic [3:0] EV_MID_DN   = 4'd3;
    localparam logic [3:0] EV_RIGHT_UP = 4'd4;
    localparam logic [3:0] EV_RIGHT_DN = 4'd5;
    localparam logic [3:0] EV_MID2_UP  = 4'd6;
    localparam logic [3:0] EV_MID2_DN  = 4'd7;
    localparam logic [3:0] EV_MOTION   = 4'd8;
    localparam logic [3:0] EV_NONE     = 4'd9;

    // one closed packet, as handed from the framer to the decoder
    typedef struct packed {
        logic [6:0] header;
        logic [5:0] x_low;
        logic [5:0] y_low;
        logic [1:0] extra;   // bit1 middle, bit0 second middle
    } packet_t;

endpackage

`default_nettype wire

// ===== sv/smpd_framer.sv =====
// Packet framer: tracks the frame phase and collects header, X, Y and fourth byte.
// Depends on smpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smpd_framer (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,      // registered item is processed this cycle
    input  wire logic             op,
    input  wire logic [7:0]       rx_byte,
    output logic                  close,     // item closes a held packet
    output smpd_pkg::packet_t     pkt
);

    logic [1:0] phase_reg, phase_next;
    logic [6:0] header_reg, header_next;
    logic [5:0] x_reg, x_next;
    logic [5:0] y_reg, y_next;
    logic [1:0] extra_reg, extra_next;

    logic idle;
    logic hdr;

    assign idle = (op == smpd_pkg::OP_IDLE);
    assign hdr  = rx_byte[smpd_pkg::HdrBit];

    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        extra_next  = extra_reg;
        close       = 1'b0;
        if (phase_reg == smpd_pkg::PH_HELD) begin
            close = 1'b1;
            if (idle) begin
                phase_next = smpd_pkg::PH_HUNT;
            end else if (hdr) begin
                header_next = rx_byte[6:0];
                phase_next  = smpd_pkg::PH_B2;
            end else begin
                extra_next = rx_byte[5:4];
                phase_next = smpd_pkg::PH_HUNT;
            end
        end else if (!idle) begin
            if (hdr) begin
                // early header restarts the packet
                header_next = rx_byte[6:0];
                phase_next  = smpd_pkg::PH_B2;
            end else begin
                case (phase_reg)
                    smpd_pkg::PH_B2: begin
                        x_next     = rx_byte[5:0];
                        phase_next = smpd_pkg::PH_B3;
                    end
                    smpd_pkg::PH_B3: begin
                        y_next     = rx_byte[5:0];
                        phase_next = smpd_pkg::PH_HELD;
                    end
                    default: begin
                        // stray byte while hunting is dropped
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // fourth byte is used by the packet it closes; a header or idle uses the old one
    always_comb begin
        pkt.header = header_reg;
        pkt.x_low  = x_reg;
        pkt.y_low  = y_reg;
        pkt.extra  = (!idle && !hdr) ? rx_byte[5:4] : extra_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= smpd_pkg::PH_HUNT;
            header_reg <= 7'd0;
            x_reg      <= 6'd0;
            y_reg      <= 6'd0;
            extra_reg  <= 2'd0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            extra_reg  <= extra_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/smpd_decode.sv =====
// Packet decoder: motion, button state and prioritized event, into the result register.
// Depends on smpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smpd_decode (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    fire,
    input  wire logic                    close,
    input  wire smpd_pkg::packet_t       pkt,
    input  wire logic                    out_free,   // result register may be loaded
    output logic                         res_valid,
    output logic [3:0]                   event_res,
    output logic signed [7:0]            delta_x,
    output logic signed [7:0]            delta_y,
    output logic [3:0]                   buttons
);

    logic [3:0] last_buttons_reg;
    logic       valid_reg;
    logic [3:0] event_reg, event_next;
    logic [7:0] dx_reg, dx_next;
    logic [7:0] dy_reg, dy_next;
    logic [3:0] buttons_reg, buttons_next;

    logic [3:0] diff;
    logic       emit;

    assign emit = fire && close;

    always_comb begin
        buttons_next = {pkt.extra[0], pkt.header[4], pkt.extra[1], pkt.header[5]};
        dx_next      = {pkt.header[1:0], pkt.x_low};
        dy_next      = {pkt.header[3:2], pkt.y_low};
        diff         = buttons_next ^ last_buttons_reg;
        // left, middle, second middle, right, then motion
        if (diff[0]) begin
            event_next = buttons_next[0] ? smpd_pkg::EV_LEFT_DN : smpd_pkg::EV_LEFT_UP;
        end else if (diff[1]) begin
            event_next = buttons_next[1] ? smpd_pkg::EV_MID_DN : smpd_pkg::EV_MID_UP;
        end else if (diff[3]) begin
            event_next = buttons_next[3] ? smpd_pkg::EV_MID2_DN : smpd_pkg::EV_MID2_UP;
        end else if (diff[2]) begin
            event_next = buttons_next[2] ? smpd_pkg::EV_RIGHT_DN : smpd_pkg::EV_RIGHT_UP;
        end else if (dx_next != 8'd0 || dy_next != 8'd0) begin
            event_next = smpd_pkg::EV_MOTION;
        end else begin
            event_next = smpd_pkg::EV_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_buttons_reg <= 4'd0;
            valid_reg        <= 1'b0;
        end else begin
            if (emit) begin
                last_buttons_reg <= buttons_next;
            end
            if (out_free) begin
                valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            event_reg   <= event_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            buttons_reg <= buttons_next;
        end
    end

    assign res_valid = valid_reg;
    assign event_res = event_reg;
    assign delta_x   = dx_reg;
    assign delta_y   = dy_reg;
    assign buttons   = buttons_reg;

endmodule

`default_nettype wire

// ===== sv/serial_mouse_packet_decoder.sv =====
// Serial mouse packet decoder, top level: input register, framer and decoder.
// Depends on smpd_pkg, smpd_framer and smpd_decode.
// Accepts one beat per cycle, a received byte or an idle-gap marker (s_tuser), as long
// as results are taken when offered. While a result waits on m_* with m_tready low,
// nothing is processed: the input register holds its beat, and s_tready is low once
// a beat is held, until the result is taken. An accepted beat sits in the input register
// and is processed by the framer and decoder into the result register, which drives
// m_tvalid, once that register is free or its result is taken. A held three-byte
// packet is closed by the next beat of any kind: a non-header byte
// becomes its fourth byte, a header or idle gap reuses the previous fourth byte.
// Stray bytes and incomplete packets produce no result.
`timescale 1ns / 1ps
`default_nettype none

module serial_mouse_packet_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,    // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [7:0] delta_x, [15:8] delta_y, [19:16] buttons
    output logic [3:0]       m_tuser     // [3:0] event_res
);

    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] byte_reg;

    logic       out_free;
    logic       fire;
    logic       close;
    smpd_pkg::packet_t pkt;

    logic        res_valid;
    logic [3:0]  event_res;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [3:0]  buttons;

    assign out_free = !res_valid || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser[0];
            byte_reg <= s_tdata;
        end
    end

    smpd_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .op      (op_reg),
        .rx_byte (byte_reg),
        .close   (close),
        .pkt     (pkt)
    );

    smpd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .close     (close),
        .pkt       (pkt),
        .out_free  (out_free),
        .res_valid (res_valid),
        .event_res (event_res),
        .delta_x   (delta_x),
        .delta_y   (delta_y),
        .buttons   (buttons)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {4'd0, buttons, delta_y, delta_x};
    assign m_tuser  = event_res;

endmodule

`default_nettype wire

// ===== sv/smpd_checker.sv =====
// Port-level checker for the serial mouse packet decoder, bound to the top level.
// Depends on smpd_pkg and serial_mouse_packet_decoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_mouse_packet_decoder_defines.svh"

module smpd_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic [3:0]  m_tuser
);

    // no result beat right after reset
    `SMPD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // stalled result beat holds
    `SMPD_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // motion event only with nonzero motion
    `SMPD_ASSERT(a_motion_nonzero, aclk, aresetn, m_tvalid && m_tuser == smpd_pkg::EV_MOTION |-> m_tdata[15:0] != 16'd0, "motion event with zero deltas")

    // no-event result only with zero motion
    `SMPD_ASSERT(a_none_zero, aclk, aresetn, m_tvalid && m_tuser == smpd_pkg::EV_NONE |-> m_tdata[15:0] == 16'd0, "none event with motion")

endmodule

bind serial_mouse_packet_decoder smpd_checker u_smpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/tb_serial_mouse_packet_decoder.sv =====
// Self-checking testbench for serial_mouse_packet_decoder: directed table, then random
// packets and noise, checked beat by beat against a cycle-free framing predictor.
// Depends on smpd_pkg and serial_mouse_packet_decoder.
`timescale 1ns / 1ps

module tb_serial_mouse_packet_decoder;

    localparam int NUM_RANDOM  = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [3:0] ev;
        logic [3:0] btn;
        logic [7:0] dy;
        logic [7:0] dx;
    } mouse_report_t;

    typedef struct {
        logic          op;
        logic [7:0]    data;
        bit            typed;
        mouse_report_t rep;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;

    serial_mouse_packet_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [1:0] fr_phase;
    logic [6:0] hdr_q;
    logic [5:0] x_q;
    logic [5:0] y_q;
    logic [1:0] extra_q;
    logic [3:0] btn_q;

    mouse_report_t expected_reports[$];
    dir_row_t      dir_rows[$];
    int            errors   = 0;
    int            beats_in = 0;
    bit            calm     = 1'b0;
    logic [1:0]    lr_bits  = 2'b00;   // left/right kept between packets
    logic [1:0]    mid_bits = 2'b00;   // middle/second middle of the fourth byte

    function automatic mouse_report_t close_packet();
        logic [3:0]    now;
        logic [3:0]    diff;
        mouse_report_t r;
        now   = {extra_q[0], hdr_q[4], extra_q[1], hdr_q[5]};
        diff  = now ^ btn_q;
        r.dx  = {hdr_q[1:0], x_q};
        r.dy  = {hdr_q[3:2], y_q};
        r.btn = now;
        if (diff[0])
            r.ev = now[0] ? smpd_pkg::EV_LEFT_DN : smpd_pkg::EV_LEFT_UP;
        else if (diff[1])
            r.ev = now[1] ? smpd_pkg::EV_MID_DN : smpd_pkg::EV_MID_UP;
        else if (diff[3])
            r.ev = now[3] ? smpd_pkg::EV_MID2_DN : smpd_pkg::EV_MID2_UP;
        else if (diff[2])
            r.ev = now[2] ? smpd_pkg::EV_RIGHT_DN : smpd_pkg::EV_RIGHT_UP;
        else if (r.dx != 8'h00 || r.dy != 8'h00)
            r.ev = smpd_pkg::EV_MOTION;
        else
            r.ev = smpd_pkg::EV_NONE;
        btn_q = now;
        return r;
    endfunction

    // advance the framer by one beat; returns 1 when a packet closes
    function automatic bit frame_beat(input logic op, input logic [7:0] b,
                                      output mouse_report_t rep);
        bit is_hdr;
        is_hdr = b[smpd_pkg::HdrBit];
        rep    = '0;
        if (fr_phase == smpd_pkg::PH_HELD) begin
            if (op == smpd_pkg::OP_BYTE && !is_hdr)
                extra_q = b[5:4];
            rep = close_packet();
            if (op == smpd_pkg::OP_BYTE && is_hdr) begin
                hdr_q    = b[6:0];
                fr_phase = smpd_pkg::PH_B2;
            end else begin
                fr_phase = smpd_pkg::PH_HUNT;
            end
            return 1'b1;
        end
        if (op == smpd_pkg::OP_IDLE)
            return 1'b0;
        if (is_hdr) begin
            hdr_q    = b[6:0];
            fr_phase = smpd_pkg::PH_B2;
        end else if (fr_phase == smpd_pkg::PH_B2) begin
            x_q      = b[5:0];
            fr_phase = smpd_pkg::PH_B3;
        end else if (fr_phase == smpd_pkg::PH_B3) begin
            y_q      = b[5:0];
            fr_phase = smpd_pkg::PH_HELD;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input logic op, input logic [7:0] b, input bit typed,
                             input mouse_report_t typed_rep);
        int            gap;
        mouse_report_t rep;
        gap = pick_gap(calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        beats_in++;
        if (frame_beat(op, b, rep))
            expected_reports.push_back(typed ? typed_rep : rep);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(smpd_pkg::OP_BYTE, b, 1'b0, '0);
    endtask

    task automatic send_random_packet();
        logic [7:0] hb;
        logic [7:0] xb;
        logic [7:0] yb;
        int         kind;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            if ($urandom_range(0, 3) == 0)
                lr_bits ^= 2'($urandom_range(1, 3));
            hb = {1'($urandom), 1'b1, lr_bits, 4'($urandom)};
            xb = {1'($urandom), 1'b0, 6'($urandom)};
            yb = {1'($urandom), 1'b0, 6'($urandom)};
            if ($urandom_range(0, 9) == 0) begin
                // still packet
                hb[3:0] = 4'h0;
                xb[5:0] = 6'h00;
                yb[5:0] = 6'h00;
            end
            send_byte(hb);
            send_byte(xb);
            send_byte(yb);
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                if ($urandom_range(0, 2) == 0)
                    mid_bits ^= 2'($urandom_range(1, 3));
                send_byte({1'($urandom), 1'b0, mid_bits, 4'($urandom)});
            end else if (kind < 65) begin
                send_beat(smpd_pkg::OP_IDLE, 8'($urandom), 1'b0, '0);
            end
            // otherwise the next beat closes the packet
        end else begin
            repeat ($urandom_range(1, 4)) begin
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    send_byte(8'($urandom));
                end else if (kind < 6) begin
                    send_beat(smpd_pkg::OP_IDLE, 8'($urandom), 1'b0, '0);
                end else begin
                    // broken frame: header with at most one data byte
                    send_byte({1'($urandom), 1'b1, 6'($urandom)});
                    if ($urandom_range(0, 1) == 1)
                        send_byte({1'($urandom), 1'b0, 6'($urandom)});
                end
            end
        end
    endtask

    // result side: random stalls plus one long hold-off so the input backs up
    int  stall_cnt = 0;
    int  hold_cnt  = 0;
    bit  hold_done = 1'b0;

    initial m_tready = 1'b0;

    always @(posedge aclk) begin
        mouse_report_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("unexpected result: tuser=%0d tdata=%h", m_tuser, m_tdata);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tuser !== want.ev || m_tdata[7:0] !== want.dx ||
                        m_tdata[15:8] !== want.dy || m_tdata[19:16] !== want.btn ||
                        m_tdata[23:20] !== 4'h0) begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display("mismatch: ev %0d/%0d dx %h/%h dy %h/%h btn %h/%h pad %h",
                                     want.ev, m_tuser, want.dx, m_tdata[7:0], want.dy,
                                     m_tdata[15:8], want.btn, m_tdata[19:16],
                                     m_tdata[23:20]);
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (!hold_done && beats_in >= 250) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                stall_cnt = pick_gap(calm);
                m_tready <= (stall_cnt == 0);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit drained;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = smpd_pkg::OP_BYTE;
        fr_phase = smpd_pkg::PH_HUNT;
        hdr_q    = '0;
        x_q      = '0;
        y_q      = '0;
        extra_q  = '0;
        btn_q    = '0;
        drained  = 1'b0;

        // op, rx_byte, typed, {event, buttons, dy, dx}
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h15, 1'b0, '0});   // stray byte while hunting
        dir_rows.push_back('{smpd_pkg::OP_IDLE, 8'h00, 1'b0, '0});   // idle while hunting
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h40, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_IDLE, 8'hFF, 1'b1,
                             '{smpd_pkg::EV_NONE, 4'h0, 8'h00, 8'h00}});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h7F, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'hBF, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'hBF, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h30, 1'b1,
                             '{smpd_pkg::EV_LEFT_DN, 4'hF, 8'hFF, 8'hFF}});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'hC0, 1'b0, '0});   // header with bit 7 set
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h62, 1'b0, '0});   // header in place of byte 2
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h50, 1'b0, '0});   // header in place of byte 3
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h20, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h01, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h40, 1'b0, '0});   // header closes held packet
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h48, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h10, 1'b1,
                             '{smpd_pkg::EV_MID2_DN, 4'h8, 8'h80, 8'h00}});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h51, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h01, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{smpd_pkg::OP_IDLE, 8'h00, 1'b0, '0});   // idle closes, old 4th byte

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].rep);

        while (beats_in < dir_rows.size() + NUM_RANDOM) begin
            if ($urandom_range(0, 7) == 0)
                calm = ~calm;
            send_random_packet();
            if (!drained && beats_in >= 400) begin
                // sender pause until the block has delivered everything
                drained = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (expected_reports.size() != 0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_reports.size() != 0);
        repeat (20) @(posedge aclk);

        if (errors == 0 && expected_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
